@@ rtl/core/gfgc_pkg.sv @@
package gfgc_pkg;

   // Finger pairs across the hand; slots are left half then right half
   localparam int PAIRS = 10;
   localparam int SLOTS = 2 * PAIRS;

   localparam int COORD_W  = 24;
   localparam int WIDTH_W  = 16;
   localparam int DIAM_W   = 17;
   localparam int STEP_W   = 16;
   localparam int DEPTH_W  = 16;
   localparam int TARGET_W = 4;

   // Slot bounds reach (PAIRS-1)*step + 2*width, plus sign
   localparam int BOUND_W = 26;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 17;

   localparam logic [CSR_INDEX_W-1:0] CSR_FINGER_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTER_DIAM    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT_STEP     = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HAND_DEPTH    = 2'd3;

   localparam logic [WIDTH_W-1:0] RESET_FINGER_WIDTH = 16'd655;
   localparam logic [DIAM_W-1:0]  RESET_OUTER_DIAM   = 17'd6881;
   localparam logic [STEP_W-1:0]  RESET_SLOT_STEP    = 16'd692;
   localparam logic [DEPTH_W-1:0] RESET_HAND_DEPTH   = 16'd3932;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   // One classified point as it travels from the front to the back
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic                      cropped;
      logic                      collide;
      logic                      select_all;
      logic [TARGET_W-1:0]       target_pair;
      logic                      last_point;
   } point_type;

   // Slot windows, each open on both ends
   typedef struct packed {
      logic signed [BOUND_W-1:0] lo;
      logic signed [BOUND_W-1:0] hi;
   } window_type;

   typedef window_type [SLOTS-1:0] window_set_type;

endpackage

@@ rtl/core/gfgc_slots.sv @@
module gfgc_slots
   import gfgc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output logic [DEPTH_W-1:0]     base_depth,
   output window_set_type         windows
);

   logic [WIDTH_W-1:0] width_ff, width_in;
   logic [DIAM_W-1:0]  diam_ff, diam_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;

   logic signed [BOUND_W-1:0] right_ff [PAIRS];
   logic signed [BOUND_W-1:0] width_ext_ff;
   logic signed [BOUND_W-1:0] left_off_ff;
   logic signed [BOUND_W-1:0] left_off_hi_ff;
   window_set_type            windows_ff;

   always_comb begin
      width_in = width_ff;
      diam_in  = diam_ff;
      step_in  = step_ff;
      depth_in = depth_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FINGER_WIDTH: width_in = csr_data[WIDTH_W-1:0];
            CSR_OUTER_DIAM:   diam_in  = csr_data[DIAM_W-1:0];
            CSR_SLOT_STEP:    step_in  = csr_data[STEP_W-1:0];
            CSR_HAND_DEPTH:   depth_in = csr_data[DEPTH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= RESET_FINGER_WIDTH;
         diam_ff  <= RESET_OUTER_DIAM;
         step_ff  <= RESET_SLOT_STEP;
         depth_ff <= RESET_HAND_DEPTH;
      end else begin
         width_ff <= width_in;
         diam_ff  <= diam_in;
         step_ff  <= step_in;
         depth_ff <= depth_in;
      end
   end

   // First stage: the extended finger width and the left-slot offsets
   always_ff @(posedge clock) begin
      width_ext_ff   <= $signed(BOUND_W'(width_ff));
      left_off_ff    <= $signed(BOUND_W'(width_ff)) - $signed(BOUND_W'(diam_ff));
      left_off_hi_ff <= $signed(BOUND_W'({width_ff, 1'b0})) - $signed(BOUND_W'(diam_ff));
   end

   // Right starts in the first stage, then the bounds in the second (an add for all but right lo)
   always_ff @(posedge clock) begin
      for (int k = 0; k < PAIRS; k++) begin
         right_ff[k]              <= $signed(BOUND_W'(k) * BOUND_W'(step_ff));
         windows_ff[k].lo         <= right_ff[k] + left_off_ff;
         windows_ff[k].hi         <= right_ff[k] + left_off_hi_ff;
         windows_ff[PAIRS + k].lo <= right_ff[k];
         windows_ff[PAIRS + k].hi <= right_ff[k] + width_ext_ff;
      end
   end

   assign base_depth = depth_ff;
   assign windows    = windows_ff;

endmodule

@@ rtl/core/gfgc_front.sv @@
module gfgc_front
   import gfgc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic signed [COORD_W-1:0] req_point_x,
   input  logic signed [COORD_W-1:0] req_point_y,
   input  logic signed [COORD_W-1:0] req_bite,
   input  logic                      req_select_all,
   input  logic [TARGET_W-1:0]       req_target_pair,
   input  logic                      req_last_point,
   input  logic [DEPTH_W-1:0]        base_depth,
   input  logic                      queue_full,
   output logic                      queue_push,
   output point_type                 queue_entry
);

   logic      valid_ff, valid_in;
   point_type entry_ff;
   logic      accept;

   logic signed [BOUND_W-1:0] y_ext;
   logic signed [BOUND_W-1:0] bite_ext;
   logic signed [BOUND_W-1:0] base_line;
   logic                      cropped;

   assign y_ext     = BOUND_W'(req_point_y);
   assign bite_ext  = BOUND_W'(req_bite);
   assign base_line = bite_ext - $signed(BOUND_W'(base_depth));
   assign cropped   = req_point_y < req_bite;

   assign req_full   = valid_ff && queue_full;
   assign accept     = req_push && !req_full;
   assign queue_push = valid_ff && !queue_full;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (queue_push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Classify on the way in: cropped and below-base flags
   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff.x           <= req_point_x;
         entry_ff.cropped     <= cropped;
         entry_ff.collide     <= cropped && (y_ext < base_line);
         entry_ff.select_all  <= req_select_all;
         entry_ff.target_pair <= req_target_pair;
         entry_ff.last_point  <= req_last_point;
      end
   end

   assign queue_entry = entry_ff;

endmodule

@@ rtl/core/gfgc_queue.sv @@
module gfgc_queue
   import gfgc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  point_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output point_type head_entry
);

   point_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign full       = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ rtl/core/gfgc_back.sv @@
module gfgc_back
   import gfgc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  point_type           head_entry,
   output logic                queue_pop,
   input  window_set_type      windows,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [SLOTS-1:0]    rsp_finger_free,
   output logic [PAIRS-1:0]    rsp_hand_ok,
   output logic                rsp_collided,
   output logic                rsp_none_cropped
);

   logic [SLOTS-1:0] occupied_ff, occupied_in;
   logic             collision_ff, collision_in;
   logic             cropped_ff, cropped_in;

   logic             rsp_valid_ff;
   logic [SLOTS-1:0] free_ff;
   logic [PAIRS-1:0] hand_ff;
   logic             collided_ff;
   logic             none_cropped_ff;

   logic                      out_room;
   logic                      finish;
   logic signed [BOUND_W-1:0] x_ext;
   logic [SLOTS-1:0]          hits;
   logic [SLOTS-1:0]          select_mask;
   logic [SLOTS-1:0]          free_mask;
   logic [PAIRS-1:0]          hand_mask;

   assign out_room  = !rsp_valid_ff || rsp_pop;
   assign queue_pop = head_valid && (!head_entry.last_point || out_room);
   assign finish    = queue_pop && head_entry.last_point;
   assign x_ext     = BOUND_W'(head_entry.x);

   // All slot windows tested at once
   for (genvar s = 0; s < SLOTS; s++) begin : g_slot
      assign hits[s] = head_entry.cropped && (x_ext > windows[s].lo) &&
                       (x_ext < windows[s].hi);
   end

   for (genvar k = 0; k < PAIRS; k++) begin : g_sel
      assign select_mask[k] = head_entry.select_all ||
                              (32'(head_entry.target_pair) == k);
      assign select_mask[PAIRS + k] = select_mask[k];
   end

   assign occupied_in  = occupied_ff | hits;
   assign collision_in = collision_ff | head_entry.collide;
   assign cropped_in   = cropped_ff | head_entry.cropped;

   always_comb begin
      free_mask = '0;
      if (!collision_in && cropped_in) begin
         free_mask = ~occupied_in & select_mask;
      end
      hand_mask = free_mask[PAIRS-1:0] & free_mask[SLOTS-1:PAIRS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occupied_ff  <= '0;
         collision_ff <= 1'b0;
         cropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (finish) begin
            occupied_ff  <= '0;
            collision_ff <= 1'b0;
            cropped_ff   <= 1'b0;
         end else if (queue_pop) begin
            occupied_ff  <= occupied_in;
            collision_ff <= collision_in;
            cropped_ff   <= cropped_in;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         free_ff         <= free_mask;
         hand_ff         <= hand_mask;
         collided_ff     <= collision_in;
         none_cropped_ff <= !cropped_in;
      end
   end

   assign rsp_empty        = !rsp_valid_ff;
   assign rsp_finger_free  = free_ff;
   assign rsp_hand_ok      = hand_ff;
   assign rsp_collided     = collided_ff;
   assign rsp_none_cropped = none_cropped_ff;

endmodule

@@ rtl/core/gripper_finger_gap_check.sv @@
// Gripper finger gap check: streams the points of one batch and reports free finger slots.
//
// Input channel: one point per item on req_*; an item is taken on a clock edge with
// req_push high and req_full low. Mark the final point of a batch with req_last_point.
// Result channel: one item per batch, on rsp_*, valid while rsp_empty is low and taken
// on an edge with rsp_pop high. Points that are not last give no result.
// Configuration: csr_valid/csr_ready with csr_index (0 finger width, 1 outer diameter,
// 2 slot step, 3 hand depth) and csr_data. csr_ready is always high. Write only while
// idle; the hand depth applies to points pushed after the write, while the slot windows
// follow it through the configuration, first-stage and window registers.
// Throughput: one point per cycle while no result waits unpopped; the 20 slot windows are
// compared in parallel by the back end, so nothing iterates per point.
// Path: the last point passes the front register, then the four-entry point queue,
// and its result is then held in the back end's result register.
// Stalls: while a result waits unpopped, the back end holds the next last point at the
// queue head and everything behind it waits; points ahead of it still drain, and
// req_full rises only once the queue and the front register are both full.
// Reset: clears the batch state, the queue and the result; configuration returns to
// its defaults (655, 6881, 692, 3932).
module gripper_finger_gap_check
   import gfgc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_push,
   output logic                      req_full,
   input  logic signed [COORD_W-1:0] req_point_x,
   input  logic signed [COORD_W-1:0] req_point_y,
   input  logic signed [COORD_W-1:0] req_bite,
   input  logic                      req_select_all,
   input  logic [TARGET_W-1:0]       req_target_pair,
   input  logic                      req_last_point,

   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [SLOTS-1:0]          rsp_finger_free,
   output logic [PAIRS-1:0]          rsp_hand_ok,
   output logic                      rsp_collided,
   output logic                      rsp_none_cropped,

   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data
);

   logic [DEPTH_W-1:0] base_depth;
   window_set_type     windows;

   logic      queue_full;
   logic      queue_push;
   point_type queue_entry;
   logic      head_valid;
   point_type head_entry;
   logic      queue_pop;

   // Configuration is never back-pressured
   assign csr_ready = 1'b1;

   // Hold the configuration and derive the slot windows from it
   gfgc_slots u_slots (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .base_depth (base_depth),
      .windows    (windows)
   );

   // Take points and flag cropped and below-base ones
   gfgc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_bite        (req_bite),
      .req_select_all  (req_select_all),
      .req_target_pair (req_target_pair),
      .req_last_point  (req_last_point),
      .base_depth      (base_depth),
      .queue_full      (queue_full),
      .queue_push      (queue_push),
      .queue_entry     (queue_entry)
   );

   // Decouple the front from the back so each may stall on its own
   gfgc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_entry (queue_entry),
      .full       (queue_full),
      .pop        (queue_pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // Accumulate slot occupancy and emit the batch result
   gfgc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_entry       (head_entry),
      .queue_pop        (queue_pop),
      .windows          (windows),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_finger_free  (rsp_finger_free),
      .rsp_hand_ok      (rsp_hand_ok),
      .rsp_collided     (rsp_collided),
      .rsp_none_cropped (rsp_none_cropped)
   );

endmodule
